@@ hw/rtl/rmc_pkg.sv @@
// shared types, constants and header byte helpers for the rtmp message chunker
package rmc_pkg;

    localparam int CSID_W   = 17;
    localparam int LEN_W    = 24;
    localparam int CFG_W    = 24;
    localparam int POS_W    = 4;

    localparam logic [CSID_W-1:0] CSID_MAX    = 17'd65599;
    localparam logic [CSID_W-1:0] CSID_RESET  = 17'd3;
    localparam logic [CSID_W-1:0] CSID_ONE_LIM = 17'd64;
    localparam logic [CSID_W-1:0] CSID_TWO_LIM = 17'd320;
    localparam logic [LEN_W-1:0]  CHUNK_RESET = 24'd128;
    localparam logic [7:0]        FMT_MASK    = 8'hc0;
    localparam logic [7:0]        ID_MASK     = 8'h3f;
    localparam logic [7:0]        THREE_MARK  = 8'h01;
    localparam logic [POS_W-1:0]  T0_BODY_LEN = 4'd11;

    localparam logic REG_CSID  = 1'b0;
    localparam logic REG_CHUNK = 1'b1;

    localparam logic [1:0] FMT_T0 = 2'd0;
    localparam logic [1:0] FMT_T3 = 2'd3;

    typedef enum logic [1:0] {
        HDR_NONE,
        HDR_T0,
        HDR_T3
    } hdr_kind_t;

    typedef struct packed {
        logic [7:0]       payload;
        logic [LEN_W-1:0] timestamp;
        logic [LEN_W-1:0] length;
        logic [7:0]       mtype;
        logic [31:0]      mstream;
        hdr_kind_t        hdr;
        logic             chunk_end;
    } rmc_item_t;

    // number of basic header bytes for a clamped csid
    function automatic logic [1:0] basic_len(input logic [CSID_W-1:0] id);
        logic [1:0] n;
        begin
            if (id < CSID_ONE_LIM)
                n = 2'd1;
            else if (id < CSID_TWO_LIM)
                n = 2'd2;
            else
                n = 2'd3;
            return n;
        end
    endfunction

    function automatic logic [7:0] basic_byte(input logic [CSID_W-1:0] id,
                                              input logic [1:0]        fmt,
                                              input logic [1:0]        k);
        logic [7:0]        top;
        logic [CSID_W-1:0] idm;
        logic [7:0]        b;
        begin
            top = {fmt, 6'd0};
            idm = id - CSID_ONE_LIM;
            b   = idm[7:0];
            if (id < CSID_ONE_LIM)
                b = top | (id[7:0] & ID_MASK);
            else if (k == 2'd0)
                b = (id < CSID_TWO_LIM) ? (top & FMT_MASK) : ((top & FMT_MASK) | THREE_MARK);
            else if (k == 2'd2)
                b = idm[15:8];
            return b;
        end
    endfunction

endpackage

@@ hw/rtl/rmc_track.sv @@
// configuration registers and per-message byte counters, decides the header of each request
module rmc_track
    import rmc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                accept,
    input  logic [7:0]          payload_byte,
    input  logic [LEN_W-1:0]    message_length,
    input  logic [LEN_W-1:0]    message_timestamp,
    input  logic [7:0]          message_type,
    input  logic [31:0]         message_stream,
    output rmc_item_t           item,
    output logic [CSID_W-1:0]   csid
);

    logic [CSID_W-1:0] csid_reg;
    logic [LEN_W-1:0]  chunk_reg;
    logic [LEN_W-1:0]  bim_reg, bim_next;
    logic [LEN_W-1:0]  bic_reg, bic_next;
    logic [LEN_W-1:0]  latched_reg, latched_next;

    logic [LEN_W-1:0]  size;
    logic              first;
    logic              type3;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  bic_base;
    logic [LEN_W-1:0]  bic_inc;
    logic [LEN_W-1:0]  bim_inc;
    logic              msg_done;

    always_comb
    begin
        size     = (chunk_reg == '0) ? LEN_W'(1) : chunk_reg;
        first    = (bim_reg == '0);
        len      = first ? ((message_length == '0) ? LEN_W'(1) : message_length) : latched_reg;
        type3    = !first && (bic_reg >= size);
        bic_base = (first || type3) ? '0 : bic_reg;
        bic_inc  = bic_base + LEN_W'(1);
        bim_inc  = bim_reg + LEN_W'(1);
        msg_done = (bim_inc >= len);

        item.payload   = payload_byte;
        item.timestamp = message_timestamp;
        item.length    = len;
        item.mtype     = message_type;
        item.mstream   = message_stream;
        item.hdr       = first ? HDR_T0 : (type3 ? HDR_T3 : HDR_NONE);
        item.chunk_end = (bic_inc >= size) || msg_done;

        bim_next     = bim_reg;
        bic_next     = bic_reg;
        latched_next = latched_reg;
        if (accept)
        begin
            latched_next = len;
            bim_next     = msg_done ? '0 : bim_inc;
            bic_next     = msg_done ? '0 : bic_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            csid_reg    <= CSID_RESET;
            chunk_reg   <= CHUNK_RESET;
            bim_reg     <= '0;
            bic_reg     <= '0;
            latched_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_CSID:  csid_reg  <= cfg_data[CSID_W-1:0];
                    REG_CHUNK: chunk_reg <= cfg_data[LEN_W-1:0];
                    default:   ;
                endcase
            end
            bim_reg     <= bim_next;
            bic_reg     <= bic_next;
            latched_reg <= latched_next;
        end
    end

    // ids above the top of the three-byte range saturate
    assign csid = (csid_reg > CSID_MAX) ? CSID_MAX : csid_reg;

endmodule

@@ hw/rtl/rmc_emit.sv @@
// request holding register, byte sequencer and output register
module rmc_emit
    import rmc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  rmc_item_t         item_in,
    input  logic [CSID_W-1:0] csid,
    output logic              item_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              run_last,
    output logic              chunk_end
);

    rmc_item_t        item_reg;
    logic             item_valid_reg, item_valid_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg;
    logic             run_last_reg;
    logic             chunk_end_reg;

    logic [1:0]       bh;
    logic [POS_W-1:0] bh_used;
    logic [POS_W-1:0] total;
    logic [POS_W-1:0] j;
    logic [1:0]       fmt;
    logic [7:0]       cur_byte;
    logic             is_last;
    logic             advance;

    always_comb
    begin
        bh      = basic_len(csid);
        bh_used = (item_reg.hdr == HDR_NONE) ? '0 : POS_W'(bh);
        total   = bh_used + ((item_reg.hdr == HDR_T0) ? T0_BODY_LEN : '0) + POS_W'(1);
        is_last = (pos_reg == total - POS_W'(1));
        fmt     = (item_reg.hdr == HDR_T0) ? FMT_T0 : FMT_T3;
        j       = pos_reg - bh_used;

        cur_byte = item_reg.payload;
        if (pos_reg < bh_used)
            cur_byte = basic_byte(csid, fmt, pos_reg[1:0]);
        else if (item_reg.hdr == HDR_T0 && j < T0_BODY_LEN)
        begin
            // timestamp, length, type id, stream id, all big-endian
            case (j)
                4'd0:    cur_byte = item_reg.timestamp[23:16];
                4'd1:    cur_byte = item_reg.timestamp[15:8];
                4'd2:    cur_byte = item_reg.timestamp[7:0];
                4'd3:    cur_byte = item_reg.length[23:16];
                4'd4:    cur_byte = item_reg.length[15:8];
                4'd5:    cur_byte = item_reg.length[7:0];
                4'd6:    cur_byte = item_reg.mtype;
                4'd7:    cur_byte = item_reg.mstream[31:24];
                4'd8:    cur_byte = item_reg.mstream[23:16];
                4'd9:    cur_byte = item_reg.mstream[15:8];
                default: cur_byte = item_reg.mstream[7:0];
            endcase
        end

        advance    = item_valid_reg && (!out_valid_reg || out_ready);
        item_ready = !item_valid_reg || (advance && is_last);

        item_valid_next = item_valid_reg;
        pos_next        = pos_reg;
        if (advance)
        begin
            pos_next = is_last ? '0 : pos_reg + POS_W'(1);
            if (is_last)
                item_valid_next = 1'b0;
        end
        if (accept)
            item_valid_next = 1'b1;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            pos_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            pos_reg        <= pos_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item_in;
        if (advance)
        begin
            out_byte_reg  <= cur_byte;
            run_last_reg  <= is_last;
            chunk_end_reg <= is_last && item_reg.chunk_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;
    assign chunk_end = chunk_end_reg;

endmodule

@@ hw/rtl/rtmp_message_chunker_core.sv @@
// top level of the rtmp message chunker
// Each payload byte request is turned into its chunk stream bytes, delivered from
// an output register one byte per cycle while out_ready holds: 1 byte for a plain
// payload byte, 2 to 4 for a byte behind a type-3 basic header, and 13 to 15 for the
// first byte of a message (basic header of 1 to 3 bytes by chunk stream id, 11 type-0
// header bytes, then the payload byte). The byte sequencer sets that count; the next
// request is taken in the same cycle that the last byte of the previous one enters
// the output register, so payload-only runs flow at one byte per cycle. The user must
// write configuration only while no request is pending; the block does not enforce it.
module rtmp_message_chunker_core
    import rmc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          payload_byte,
    input  logic [LEN_W-1:0]    message_length,
    input  logic [LEN_W-1:0]    message_timestamp,
    input  logic [7:0]          message_type,
    input  logic [31:0]         message_stream,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                run_last,
    output logic                chunk_end
);

    rmc_item_t         item;
    logic [CSID_W-1:0] csid;
    logic              accept;

    assign accept = in_valid && in_ready;

    rmc_track u_track
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .accept            (accept),
        .payload_byte      (payload_byte),
        .message_length    (message_length),
        .message_timestamp (message_timestamp),
        .message_type      (message_type),
        .message_stream    (message_stream),
        .item              (item),
        .csid              (csid)
    );

    rmc_emit u_emit
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .item_in    (item),
        .csid       (csid),
        .item_ready (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .chunk_end  (chunk_end)
    );

endmodule
